// File: hw/rtl/rc4_pkg.sv
// rc4_pkg: shared types and constants for the rc4 stream cipher
// used by the channel interfaces and the top level; depends on nothing
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;
  localparam int KLEN_W     = 9;
  localparam logic [KLEN_W-1:0] KLEN_RESET = 9'd16;

  typedef logic [BYTE_W-1:0] byte_t;

  // operation codes of an input beat, code 3 is unused
  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD_N,
    ST_KS_RD_J,
    ST_KS_SWAP_A,
    ST_KS_SWAP_B,
    ST_DT_RD_I,
    ST_DT_RD_J,
    ST_DT_SWAP,
    ST_DT_OUT
  } state_t;

endpackage

// File: hw/rtl/rc4_if.sv
// rc4 channel interfaces: input items, result bytes and the key length write port
// depends on rc4_pkg
`timescale 1ns / 1ps

interface rc4_item_if;
  import rc4_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  byte_t       key_index;
  byte_t       value;

  modport source (output valid, output operation, output key_index, output value,
                  input ready);
  modport sink   (input valid, input operation, input key_index, input value,
                  output ready);
endinterface

interface rc4_result_if;
  import rc4_pkg::*;
  logic  valid;
  logic  ready;
  byte_t out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

interface rc4_cfg_if;
  import rc4_pkg::*;
  logic              valid;
  logic              ready;
  logic [KLEN_W-1:0] key_length;

  modport source (output valid, output key_length, input ready);
  modport sink   (input valid, input key_length, output ready);
endinterface

// File: hw/rtl/rc4_stream_cipher.sv
// rc4_stream_cipher: key store, permutation memory and the sequencer for
// the key schedule and the keystream generator; depends on rc4_pkg and rc4_if
//
// channel   dir   payload                          beat when
// item      in    operation, key_index, value      item.valid & item.ready
// result    out   out_byte                         result.valid & result.ready
// cfg       in    key_length                       cfg.valid & cfg.ready
//
// key byte beat: stored on accept when in range. data byte beat: DT_RD_I,
// DT_RD_J, DT_SWAP and DT_OUT from accept to a loaded result register, set by
// the single write port of the permutation memory (two reads and two writes
// per swap, third read overlaps the first write). start beat: identity fill,
// then 256 swaps through KS_RD_N, KS_RD_J, KS_SWAP_A, KS_SWAP_B before the next beat.
// rst is synchronous; it clears the sequencer, both indices, the result
// valid flag and key_length (16). memory contents are not cleared.
// a full result register stalls only the last step of a data byte; the
// input side stays ready in idle and cfg is always ready.
`timescale 1ns / 1ps

module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 256
) (
  input logic          clk,
  input logic          rst,
  rc4_item_if.sink     item,
  rc4_result_if.source result,
  rc4_cfg_if.sink      cfg
);
  import rc4_pkg::*;

  // key store address width, at least one bit
  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KLEN_W-1:0] KLEN_MAX = KLEN_W'(MAX_KEY_BYTES);

  // ---------------------------------------------------------------- registers
  state_t              state, state_next;
  logic [PERM_AW-1:0]  cnt, cnt_next;        // key schedule position n
  logic [KW-1:0]       kpos, kpos_next;      // key store position
  byte_t               idx_i, idx_i_next;
  byte_t               idx_j, idx_j_next;    // also the key schedule accumulator
  byte_t               s_a, s_a_next;        // S[n] or S[i]
  byte_t               s_b, s_b_next;        // S[j]
  byte_t               t_idx, t_idx_next;    // keystream index S[i]+S[j]
  byte_t               data, data_next;      // data byte of the beat in flight
  logic [KLEN_W-1:0]   key_length;
  logic                out_valid;
  byte_t               out_byte;

  // memory ports
  logic                perm_we;
  logic [PERM_AW-1:0]  perm_waddr;
  byte_t               perm_wdata;
  logic [PERM_AW-1:0]  perm_raddr;
  byte_t               perm_rd;
  logic                key_we;
  logic [KW-1:0]       key_raddr;
  byte_t               key_rd;

  // combinational helpers
  logic                item_beat;
  logic                key_in_range;
  logic [KLEN_W-1:0]   klen_eff;
  logic [KW-1:0]       key_last;
  byte_t               ks_acc;
  byte_t               ks_byte;
  logic                out_load;

  // ---------------------------------------------------------------- memories
  byte_t perm_mem [PERM_DEPTH];
  byte_t key_mem  [MAX_KEY_BYTES];

  // read-first: a read at the written address returns the old byte
  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
  end

  always_ff @(posedge clk) begin
    perm_rd <= perm_mem[perm_raddr];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[item.key_index[KW-1:0]] <= item.value;
    end
  end

  always_ff @(posedge clk) begin
    key_rd <= key_mem[key_raddr];
  end

  // ---------------------------------------------------------------- config port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KLEN_RESET;
    end else if (cfg.valid) begin
      key_length <= cfg.key_length;
    end
  end

  // zero or too large means the whole store
  assign klen_eff = (key_length == '0 || key_length > KLEN_MAX) ? KLEN_MAX : key_length;
  assign key_last = KW'(klen_eff - 1'b1);

  // ---------------------------------------------------------------- handshakes
  assign item.ready   = (state == ST_IDLE);
  assign item_beat    = item.valid && item.ready;
  assign key_in_range = ({1'b0, item.key_index} < KLEN_MAX);
  assign key_we       = item_beat && (item.operation == OP_KEY) && key_in_range;

  assign ks_acc = idx_j + perm_rd + key_rd;

  // keystream byte: the read of S[t] overlapped the write of S[i] and came
  // before the write of S[j], so both swapped bytes are forwarded
  always_comb begin
    priority if (t_idx == idx_j) begin
      ks_byte = s_a;
    end else if (t_idx == idx_i) begin
      ks_byte = s_b;
    end else begin
      ks_byte = perm_rd;
    end
  end

  assign out_load = (state == ST_DT_OUT) && (!out_valid || result.ready);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx_i <= '0;
      idx_j <= '0;
    end else begin
      state <= state_next;
      idx_i <= idx_i_next;
      idx_j <= idx_j_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt   <= cnt_next;
    kpos  <= kpos_next;
    s_a   <= s_a_next;
    s_b   <= s_b_next;
    t_idx <= t_idx_next;
    data  <= data_next;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    kpos_next  = kpos;
    idx_i_next = idx_i;
    idx_j_next = idx_j;
    s_a_next   = s_a;
    s_b_next   = s_b;
    t_idx_next = t_idx;
    data_next  = data;
    perm_we    = 1'b0;
    perm_waddr = cnt;
    perm_wdata = s_a;
    perm_raddr = cnt;
    key_raddr  = kpos;

    unique case (state)
      ST_IDLE: begin
        if (item_beat) begin
          unique case (item.operation)
            OP_START: begin
              state_next = ST_INIT;
              cnt_next   = '0;
              kpos_next  = '0;
              idx_j_next = '0;
            end
            OP_DATA: begin
              state_next = ST_DT_RD_I;
              idx_i_next = idx_i + 1'b1;
              data_next  = item.value;
            end
            default: begin
              // key bytes go straight into the key store, code 3 is dropped
            end
          endcase
        end
      end

      // identity fill, one entry a cycle
      ST_INIT: begin
        perm_we    = 1'b1;
        perm_waddr = cnt;
        perm_wdata = cnt;
        cnt_next   = cnt + 1'b1;
        if (cnt == '1) begin
          state_next = ST_KS_RD_N;
        end
      end

      ST_KS_RD_N: begin
        perm_raddr = cnt;
        key_raddr  = kpos;
        state_next = ST_KS_RD_J;
      end

      ST_KS_RD_J: begin
        s_a_next   = perm_rd;
        idx_j_next = ks_acc;
        perm_raddr = ks_acc;
        state_next = ST_KS_SWAP_A;
      end

      ST_KS_SWAP_A: begin
        perm_we    = 1'b1;
        perm_waddr = cnt;
        perm_wdata = perm_rd;
        state_next = ST_KS_SWAP_B;
      end

      ST_KS_SWAP_B: begin
        perm_we    = 1'b1;
        perm_waddr = idx_j;
        perm_wdata = s_a;
        cnt_next   = cnt + 1'b1;
        kpos_next  = (kpos == key_last) ? '0 : KW'(kpos + 1'b1);
        if (cnt == '1) begin
          state_next = ST_IDLE;
          idx_i_next = '0;
          idx_j_next = '0;
        end else begin
          state_next = ST_KS_RD_N;
        end
      end

      ST_DT_RD_I: begin
        perm_raddr = idx_i;
        state_next = ST_DT_RD_J;
      end

      ST_DT_RD_J: begin
        s_a_next   = perm_rd;
        idx_j_next = idx_j + perm_rd;
        perm_raddr = idx_j + perm_rd;
        state_next = ST_DT_SWAP;
      end

      ST_DT_SWAP: begin
        s_b_next   = perm_rd;
        perm_we    = 1'b1;
        perm_waddr = idx_i;
        perm_wdata = perm_rd;
        t_idx_next = s_a + perm_rd;
        perm_raddr = s_a + perm_rd;
        state_next = ST_DT_OUT;
      end

      // repeated while stalled: same write, and the re-read of S[t]
      // agrees with the forwarded bytes
      ST_DT_OUT: begin
        perm_we    = 1'b1;
        perm_waddr = idx_j;
        perm_wdata = s_a;
        perm_raddr = t_idx;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= data ^ ks_byte;
    end
  end

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;

  // ---------------------------------------------------------------- assertions
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !perm_we)
    else $error("permutation written while idle");

  a_start_enters_init: assert property (@(posedge clk) disable iff (rst)
    (item_beat && item.operation == OP_START) |=> (state == ST_INIT))
    else $error("start beat did not begin the identity fill");

  a_schedule_clears_indices: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KS_SWAP_B && cnt == '1) |=>
      (state == ST_IDLE && idx_i == '0 && idx_j == '0))
    else $error("key schedule ended with nonzero indices");

  a_result_from_data: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DT_OUT))
    else $error("result loaded outside the data path");

endmodule

// File: dv/rc4_stream_cipher_test.sv
// rc4_stream_cipher_test: self-checking bench for the rc4 stream cipher, with a directed
// known-answer table followed by random key / start / data traffic under random stalls
// depends on rc4_pkg, rc4_if and rc4_stream_cipher
`timescale 1ns / 1ps

module rc4_stream_cipher_test;
  import rc4_pkg::*;

  // code 3 has no name in the package, the block just drops it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int KEY_BYTES = 256;
  // wait out the identity fill and key schedule of a start beat, with some margin
  localparam int IDLE_WAIT = 1300;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_BEATS = 40;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [1:0] op;
    byte_t      key_index;
    byte_t      value;
    logic       typed;       // typed answer below overrides the predictor
    byte_t      typed_byte;
  } vector_row_t;

  // known answer: key "Key", plaintext "Plaintext" gives bb f3 16 e8 d9 40 af 0a d3
  localparam vector_row_t DIRECTED [23] = '{
    '{OP_UNUSED, 8'hff, 8'hff, 1'b0, 8'h00},  // unused code, no beat out
    '{OP_KEY,    8'h00, 8'h4b, 1'b0, 8'h00},  // 'K'
    '{OP_KEY,    8'h01, 8'h65, 1'b0, 8'h00},  // 'e'
    '{OP_KEY,    8'h02, 8'h79, 1'b0, 8'h00},  // 'y'
    '{OP_KEY,    8'hff, 8'h00, 1'b0, 8'h00},  // top of key store, outside key length
    '{OP_START,  8'h00, 8'h00, 1'b0, 8'h00},
    '{OP_DATA,   8'h00, 8'h50, 1'b1, 8'hbb},
    '{OP_DATA,   8'h00, 8'h6c, 1'b1, 8'hf3},
    '{OP_DATA,   8'h00, 8'h61, 1'b1, 8'h16},
    '{OP_DATA,   8'h00, 8'h69, 1'b1, 8'he8},
    '{OP_DATA,   8'h00, 8'h6e, 1'b1, 8'hd9},
    '{OP_DATA,   8'h00, 8'h74, 1'b1, 8'h40},
    '{OP_DATA,   8'h00, 8'h65, 1'b1, 8'haf},
    '{OP_DATA,   8'h00, 8'h78, 1'b1, 8'h0a},
    '{OP_DATA,   8'h00, 8'h74, 1'b1, 8'hd3},
    '{OP_DATA,   8'h00, 8'h00, 1'b0, 8'h00},  // raw keystream byte
    '{OP_DATA,   8'h00, 8'hff, 1'b0, 8'h00},
    '{OP_START,  8'h00, 8'h00, 1'b0, 8'h00},  // restart clears both indices
    '{OP_DATA,   8'h00, 8'h50, 1'b1, 8'hbb},
    '{OP_KEY,    8'h00, 8'hff, 1'b0, 8'h00},  // key change mid message, stream unaffected
    '{OP_DATA,   8'hff, 8'h00, 1'b0, 8'h00},  // key_index is ignored on data
    '{OP_UNUSED, 8'h00, 8'h00, 1'b0, 8'h00},
    '{OP_DATA,   8'h00, 8'hff, 1'b0, 8'h00}
  };

  // extremes of the key length; zero and anything past 256 mean 256
  localparam logic [8:0] FIXED_LENGTHS [5] = '{9'd16, 9'd1, 9'd256, 9'd0, 9'd511};

  logic clk = 1'b0;
  logic rst;

  rc4_item_if   item_ch ();
  rc4_result_if result_ch ();
  rc4_cfg_if    cfg_ch ();

  rc4_stream_cipher #(
    .MAX_KEY_BYTES(KEY_BYTES)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cipher state as the block should hold it
  byte_t      perm_model [PERM_DEPTH];
  byte_t      key_model [KEY_BYTES];
  byte_t      gen_i;
  byte_t      gen_j;
  logic [8:0] key_len_model = KLEN_RESET;

  // cipher bytes still to come out of the block, oldest first
  byte_t want_bytes [$];

  int    fail_count = 0;
  int    beat_count = 0;
  int    cycle_count;
  logic  no_idle = 1'b0;

  // typed answer that rides along with the beat on the item channel
  logic  beat_typed = 1'b0;
  byte_t beat_typed_byte = 8'h00;

  // generator-side view: which key bytes hold a value, and whether a start went out
  logic  key_written [KEY_BYTES];
  logic  started = 1'b0;
  int    gen_len;

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  // identity fill, then 256 swaps driven by the key bytes
  function automatic void schedule_key();
    int    len;
    int    kpos;
    byte_t acc;
    byte_t tmp;
    len = (key_len_model == 9'd0 || int'(key_len_model) > KEY_BYTES) ?
          KEY_BYTES : int'(key_len_model);
    for (int n = 0; n < PERM_DEPTH; n++)
      perm_model[n] = byte_t'(n);
    acc = 8'h00;
    kpos = 0;
    for (int n = 0; n < PERM_DEPTH; n++) begin
      acc = acc + perm_model[n] + key_model[kpos];
      tmp = perm_model[acc];
      perm_model[acc] = perm_model[n];
      perm_model[n] = tmp;
      kpos++;
      if (kpos >= len)
        kpos = 0;
    end
    gen_i = 8'h00;
    gen_j = 8'h00;
  endfunction

  function automatic byte_t next_keystream_byte();
    byte_t tmp;
    byte_t sum;
    gen_i = gen_i + 8'd1;
    gen_j = gen_j + perm_model[gen_i];
    tmp = perm_model[gen_i];
    perm_model[gen_i] = perm_model[gen_j];
    perm_model[gen_j] = tmp;
    sum = perm_model[gen_i] + perm_model[gen_j];
    return perm_model[sum];
  endfunction

  // applies one accepted item beat and queues the cipher byte it should produce
  function automatic void predict_cipher_item(input logic [1:0] op, input byte_t kidx,
                                              input byte_t val, input logic typed,
                                              input byte_t typed_byte);
    byte_t ks;
    case (op)
      OP_KEY: key_model[kidx] = val;
      OP_START: schedule_key();
      OP_DATA: begin
        ks = next_keystream_byte();
        want_bytes.push_back(typed ? typed_byte : (val ^ ks));
      end
      default: ;  // unused code: nothing changes
    endcase
  endfunction

  // everything is sampled at the rising edge, before the block's own updates land;
  // results are checked before the item of the same edge is applied
  always @(posedge clk) begin
    byte_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        key_len_model = cfg_ch.key_length;
      if (result_ch.valid && result_ch.ready) begin
        if (want_bytes.size() == 0) begin
          report_mismatch($sformatf("out_byte %02h with nothing expected",
                                    result_ch.out_byte));
        end else begin
          want = want_bytes.pop_front();
          if (result_ch.out_byte !== want)
            report_mismatch($sformatf("out_byte got %02h want %02h",
                                      result_ch.out_byte, want));
        end
      end
      if (item_ch.valid && item_ch.ready)
        predict_cipher_item(item_ch.operation, item_ch.key_index, item_ch.value,
                            beat_typed, beat_typed_byte);
    end
  end

  // result side: a random stall with ready low before taking each beat, none in no-idle messages
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        result_ch.ready = 1'b0;
      end
      @(negedge clk);
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  // one item beat: random gap with valid low, then hold valid until the block takes it;
  // valid stays up into the next beat when that one has no gap
  task automatic send_item(input logic [1:0] op, input byte_t kidx, input byte_t val,
                           input logic typed, input byte_t typed_byte);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap != 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid     = 1'b1;
    item_ch.operation = op;
    item_ch.key_index = kidx;
    item_ch.value     = val;
    beat_typed        = typed;
    beat_typed_byte   = typed_byte;
    do @(posedge clk); while (!item_ch.ready);
    beat_count++;
  endtask

  // drop valid and hold off until every cipher byte in flight has come out
  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (want_bytes.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_key_length(input logic [8:0] len);
    @(negedge clk);
    cfg_ch.valid      = 1'b1;
    cfg_ch.key_length = len;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    gen_len = int'(len);
  endtask

  // one message: key bytes (every byte the schedule reads is written at least once),
  // a start, then data beats with some noise mixed in
  task automatic run_message();
    int eff;
    int odds;
    int pick;
    int k;
    eff = (gen_len == 0 || gen_len > KEY_BYTES) ? KEY_BYTES : gen_len;
    no_idle = ($urandom_range(0, 4) == 0);
    // long keys get only a few bytes rewritten per message to keep the run short
    odds = (eff <= 16) ? 4 : 32;
    for (k = 0; k < eff; k++) begin
      if (!key_written[k] || $urandom_range(1, odds) == 1) begin
        send_item(OP_KEY, byte_t'(k), byte_t'($urandom_range(0, 255)), 1'b0, 8'h00);
        key_written[k] = 1'b1;
      end
    end
    // hold-off: let the pipe run dry before the key schedule
    if ($urandom_range(0, 9) == 0)
      wait_drained();
    // now and then skip the start and keep running the old stream
    if (!started || $urandom_range(0, 7) != 0) begin
      send_item(OP_START, byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                1'b0, 8'h00);
      started = 1'b1;
    end
    repeat ($urandom_range(1, 32)) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_item(OP_UNUSED, byte_t'($urandom_range(0, 255)),
                  byte_t'($urandom_range(0, 255)), 1'b0, 8'h00);
      end else if (pick == 1) begin
        k = $urandom_range(0, KEY_BYTES - 1);
        send_item(OP_KEY, byte_t'(k), byte_t'($urandom_range(0, 255)), 1'b0, 8'h00);
        key_written[k] = 1'b1;
      end else if (pick == 2) begin
        // a second start mid message; all needed key bytes are in place by now
        send_item(OP_START, 8'h00, 8'h00, 1'b0, 8'h00);
      end else begin
        send_item(OP_DATA, byte_t'($urandom_range(0, 255)),
                  byte_t'($urandom_range(0, 255)), 1'b0, 8'h00);
      end
    end
    no_idle = 1'b0;
  endtask

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [8:0] len;
    int         phase_start;
    item_ch.valid     = 1'b0;
    item_ch.operation = OP_KEY;
    item_ch.key_index = 8'h00;
    item_ch.value     = 8'h00;
    cfg_ch.valid      = 1'b0;
    cfg_ch.key_length = KLEN_RESET;
    for (int n = 0; n < KEY_BYTES; n++)
      key_written[n] = 1'b0;
    gen_len = int'(KLEN_RESET);

    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table runs with the three-byte key
    write_key_length(9'd3);
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].op == OP_KEY)
        key_written[DIRECTED[r].key_index] = 1'b1;
      send_item(DIRECTED[r].op, DIRECTED[r].key_index, DIRECTED[r].value,
                DIRECTED[r].typed, DIRECTED[r].typed_byte);
    end

    // random phases, each under its own key length; length only changes while idle
    for (int phase = 0; phase < 7; phase++) begin
      if (phase < 5)
        len = FIXED_LENGTHS[phase];
      else if (phase == 5)
        len = 9'($urandom_range(2, 255));
      else
        len = 9'($urandom_range(0, 511));
      wait_drained();
      repeat (IDLE_WAIT) @(posedge clk);
      write_key_length(len);
      phase_start = beat_count;
      while (beat_count - phase_start < PHASE_BEATS)
        run_message();
    end

    wait_drained();
    repeat (IDLE_WAIT) @(posedge clk);
    if (want_bytes.size() != 0)
      report_mismatch($sformatf("%0d cipher bytes never came out", want_bytes.size()));
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
